/* design/hapenv_pkg.sv */
// hapenv_pkg: shared types and fixed-point constants of the haptic envelope generator
`timescale 1ns / 1ps
`default_nettype none
package hapenv_pkg;

    localparam int LEVEL_W = 13;
    localparam int LEN_W   = 16;
    localparam int Q_W     = 17;
    localparam int ACC_W   = 29;
    localparam int MUL_W   = 18;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 13'd4096;
    localparam logic [Q_W-1:0]     ONE_Q16    = 17'd65536;
    localparam logic [MUL_W-1:0]   THREE_Q16  = 18'd196608;
    localparam logic [ACC_W-1:0]   ROUND_HALF = 29'd32768;

    // easing codes: bit 0 slow start, bit 1 slow finish
    localparam logic [1:0] EASE_NONE   = 2'b00;
    localparam logic [1:0] EASE_START  = 2'b01;
    localparam logic [1:0] EASE_FINISH = 2'b10;
    localparam logic [1:0] EASE_BOTH   = 2'b11;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    // input item payload, last field in the lowest bit
    typedef struct packed {
        logic               ease_finish;
        logic               ease_start;
        logic [LEN_W-1:0]   length_ticks;
        logic [LEVEL_W-1:0] end_level;
        logic [LEVEL_W-1:0] start_level;
        logic               hand;
    } hapenv_item_t;

    typedef struct packed {
        logic take_item;
        logic queue_write;
        logic decode;
        logic take_q;
        logic sq_step;
        logic ease_step;
        logic lo_step;
        logic hi_step;
        logic out_load;
    } hapenv_cmd_t;

    typedef struct packed {
        logic func;
        logic slot_active;
        logic t_sat;
        logic div_done;
        logic level_nz;
        logic out_free;
    } hapenv_stat_t;

endpackage
`default_nettype wire

/* design/hapenv_div.sv */
// hapenv_div: restoring divider, one quotient bit per cycle, for t = (elapsed << 16) / length
`timescale 1ns / 1ps
`default_nettype none
module hapenv_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [hapenv_pkg::LEN_W-1:0] dividend,
    input  wire logic [hapenv_pkg::LEN_W-1:0] divisor,
    output logic                             done,
    output logic [hapenv_pkg::LEN_W-1:0]     quotient
);
    import hapenv_pkg::*;

    localparam int CNT_W = $clog2(LEN_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(LEN_W - 1);

    logic [LEN_W-1:0] rem_reg;
    logic [LEN_W-1:0] quo_reg;
    logic [LEN_W-1:0] div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [LEN_W:0]   shifted;
    logic [LEN_W:0]   diff;
    logic             fits;
    logic [LEN_W-1:0] rem_next;

    // remainder stays below the divisor, so it never needs the top bit
    assign shifted  = {rem_reg, 1'b0};
    assign diff     = shifted - {1'b0, div_reg};
    assign fits     = shifted >= {1'b0, div_reg};
    assign rem_next = fits ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            div_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[LEN_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

/* design/hapenv_datapath.sv */
// hapenv_datapath: hand slots, divider, shared multiplier, easing and the output register
`timescale 1ns / 1ps
`default_nettype none
module hapenv_datapath #(
    parameter int HAND_COUNT = 2
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire hapenv_pkg::hapenv_cmd_t               cmd,
    output hapenv_pkg::hapenv_stat_t                   status,
    input  wire logic [hapenv_pkg::IN_DATA_W-1:0]      in_data,
    input  wire logic                                  in_func,
    input  wire logic                                  cfg_we,
    input  wire logic                                  cfg_value,
    input  wire logic                                  out_ready,
    output logic                                       out_valid,
    output logic                                       out_hand,
    output logic [hapenv_pkg::LEVEL_W-1:0]             out_level
);
    import hapenv_pkg::*;

    localparam int HW = (HAND_COUNT > 1) ? $clog2(HAND_COUNT) : 1;

    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
        return (v > FULL_LEVEL) ? FULL_LEVEL : v;
    endfunction

    hapenv_item_t item_reg;
    logic         func_reg;
    logic         disabled_reg;

    // per-hand slots
    logic [HAND_COUNT-1:0] busy_reg;
    logic [HAND_COUNT-1:0] started_reg;
    logic [LEVEL_W-1:0]    start_lvl_reg [HAND_COUNT];
    logic [LEVEL_W-1:0]    end_lvl_reg   [HAND_COUNT];
    logic [LEN_W-1:0]      len_reg       [HAND_COUNT];
    logic [1:0]            ease_mem_reg  [HAND_COUNT];
    logic [LEN_W-1:0]      elapsed_reg   [HAND_COUNT];

    // working registers of one tick
    logic [LEVEL_W-1:0] w_start_reg;
    logic [LEVEL_W-1:0] w_end_reg;
    logic [1:0]         w_ease_reg;
    logic [Q_W-1:0]     t_reg;
    logic [Q_W-1:0]     sq_reg;
    logic [Q_W-1:0]     e_reg;
    logic [ACC_W-1:0]   acc_reg;

    logic               out_valid_reg;
    logic               out_hand_reg;
    logic [LEVEL_W-1:0] out_level_reg;

    logic [HW-1:0]      idx;
    logic               hand_ok;
    logic [LEN_W-1:0]   el_eff;
    logic [LEN_W-1:0]   rd_len;
    logic               t_sat_w;
    logic               div_done;
    logic [LEN_W-1:0]   quotient;
    logic [Q_W-1:0]     sq_base;
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] prod;
    logic [Q_W-1:0]     e_next;
    logic [LEVEL_W-1:0] level_w;

    assign idx     = HW'(item_reg.hand);
    assign hand_ok = {31'd0, item_reg.hand} < 32'(HAND_COUNT);
    assign rd_len  = len_reg[idx];
    assign el_eff  = started_reg[idx] ? elapsed_reg[idx] : '0;
    // covers zero length as well
    assign t_sat_w = el_eff >= rd_len;

    hapenv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.decode && !t_sat_w),
        .dividend (el_eff),
        .divisor  (rd_len),
        .done     (div_done),
        .quotient (quotient)
    );

    // shared multiplier, operands picked by the current step
    assign sq_base = (w_ease_reg == EASE_FINISH) ? (ONE_Q16 - t_reg) : t_reg;

    always_comb
    begin
        priority if (cmd.sq_step)
        begin
            mul_a = {1'b0, sq_base};
            mul_b = {1'b0, sq_base};
        end
        else if (cmd.ease_step)
        begin
            mul_a = {1'b0, sq_reg};
            mul_b = THREE_Q16 - {t_reg, 1'b0};
        end
        else if (cmd.lo_step)
        begin
            mul_a = MUL_W'(w_start_reg);
            mul_b = {1'b0, ONE_Q16 - e_reg};
        end
        else
        begin
            mul_a = MUL_W'(w_end_reg);
            mul_b = {1'b0, e_reg};
        end
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        unique case (w_ease_reg)
            EASE_BOTH:   e_next = prod[Q_W+15:16];
            EASE_START:  e_next = sq_reg;
            EASE_FINISH: e_next = ONE_Q16 - sq_reg;
            EASE_NONE:   e_next = t_reg;
            default:     e_next = t_reg;
        endcase
    end

    assign level_w = acc_reg[ACC_W-1:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disabled_reg  <= 1'b0;
            busy_reg      <= '0;
            started_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                disabled_reg <= cfg_value;
            if (cmd.queue_write && !disabled_reg && hand_ok)
            begin
                busy_reg[idx]    <= 1'b1;
                started_reg[idx] <= 1'b0;
            end
            else if (cmd.decode)
            begin
                busy_reg[idx]    <= !t_sat_w;
                started_reg[idx] <= !t_sat_w;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            item_reg <= hapenv_item_t'(in_data[$bits(hapenv_item_t)-1:0]);
            func_reg <= in_func;
        end
        if (cmd.queue_write && !disabled_reg && hand_ok)
        begin
            start_lvl_reg[idx] <= clamp_level(item_reg.start_level);
            end_lvl_reg[idx]   <= clamp_level(item_reg.end_level);
            len_reg[idx]       <= item_reg.length_ticks;
            ease_mem_reg[idx]  <= {item_reg.ease_finish, item_reg.ease_start};
            elapsed_reg[idx]   <= '0;
        end
        if (cmd.decode)
        begin
            w_start_reg <= start_lvl_reg[idx];
            w_end_reg   <= end_lvl_reg[idx];
            w_ease_reg  <= ease_mem_reg[idx];
            if (t_sat_w)
                t_reg <= ONE_Q16;
            else
                elapsed_reg[idx] <= el_eff + 1'b1;
        end
        if (cmd.take_q)
            t_reg <= {1'b0, quotient};
        if (cmd.sq_step)
            sq_reg <= prod[Q_W+15:16];
        if (cmd.ease_step)
            e_reg <= e_next;
        if (cmd.lo_step)
            acc_reg <= prod[ACC_W-1:0];
        if (cmd.hi_step)
            acc_reg <= acc_reg + prod[ACC_W-1:0] + ROUND_HALF;
        if (cmd.out_load)
        begin
            out_hand_reg  <= item_reg.hand;
            out_level_reg <= level_w;
        end
    end

    always_comb
    begin
        status.func        = func_reg;
        status.slot_active = hand_ok && busy_reg[idx];
        status.t_sat       = t_sat_w;
        status.div_done    = div_done;
        status.level_nz    = level_w != '0;
        status.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_hand  = out_hand_reg;
    assign out_level = out_level_reg;

`ifndef SYNTH
    a_t_below_one: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_q |=> (t_reg < ONE_Q16))
        else $error("divided t reached one");

    a_e_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ease_step |=> (e_reg <= ONE_Q16))
        else $error("eased t above one");

    a_out_level: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (level_w != '0 && level_w <= FULL_LEVEL))
        else $error("pulse level out of range");

    for (genvar h = 0; h < HAND_COUNT; h++)
    begin : g_slot_chk
        a_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
            (busy_reg[h] && started_reg[h]) |->
                (len_reg[h] != '0 && elapsed_reg[h] <= len_reg[h]))
            else $error("slot elapsed count passed its length");
    end
`endif

endmodule
`default_nettype wire

/* design/hapenv_ctrl.sv */
// hapenv_ctrl: sequencer that steps the datapath through one item
`timescale 1ns / 1ps
`default_nettype none
module hapenv_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire hapenv_pkg::hapenv_stat_t status,
    output hapenv_pkg::hapenv_cmd_t       cmd
);
    import hapenv_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_SQ     = 3'd3;
    localparam logic [2:0] ST_EASE   = 3'd4;
    localparam logic [2:0] ST_LO     = 3'd5;
    localparam logic [2:0] ST_HI     = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = state_reg == ST_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.func)
                begin
                    cmd.queue_write = 1'b1;
                    state_next      = ST_IDLE;
                end
                else if (!status.slot_active)
                    state_next = ST_IDLE;
                else
                begin
                    cmd.decode = 1'b1;
                    state_next = status.t_sat ? ST_SQ : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.take_q = 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.sq_step = 1'b1;
                state_next  = ST_EASE;
            end
            ST_EASE:
            begin
                cmd.ease_step = 1'b1;
                state_next    = ST_LO;
            end
            ST_LO:
            begin
                cmd.lo_step = 1'b1;
                state_next  = ST_HI;
            end
            ST_HI:
            begin
                cmd.hi_step = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                // zero strength gives no pulse
                if (!status.level_nz)
                    state_next = ST_IDLE;
                else if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

/* design/haptic_envelope_generator_top.sv */
// haptic_envelope_generator_top: two-hand eased envelope generator, stream in and stream out
// Input items arrive on s_tvalid/s_tready/s_tdata with s_tuser as the kind:
// 0 is a tick for the selected hand, 1 queues a new event into that hand's slot.
// A queued event replaces any pending one; while haptics are disabled (cfg_data
// written as 1 on the cfg_valid/cfg_ready port) queued events are dropped.
// Each tick of a busy slot yields at most one pulse item on m_tvalid/m_tready/m_tdata.
// One item is worked on at a time. A queue item or a tick on an idle slot passes
// through decode only; a tick with t at one goes from decode straight to the
// multiplier steps; any other tick first waits in the bit-serial divider that
// forms elapsed/length. Squaring, easing and the two interpolation products then
// share one 18x18 multiplier, one step after another.
// The pulse sits in an output register, so the next item is taken while a pulse
// waits; if the receiver still stalls when the following pulse is ready, the
// block holds that item until the register frees.
// Reset (rst_n, asynchronous, active low) empties every slot, clears the
// disable flag and drops any pulse waiting at the output.
`timescale 1ns / 1ps
`default_nettype none
module haptic_envelope_generator_top #(
    parameter int HAND_COUNT = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // hand, start_level[12:0], end_level[12:0], length_ticks[15:0],
    // ease_start, ease_finish, zero fill
    input  wire logic [47:0] s_tdata,
    // func
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pulse_hand, pulse_level[12:0], zero fill
    output logic [15:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);
    import hapenv_pkg::*;

    hapenv_cmd_t        cmd;
    hapenv_stat_t       status;
    logic               take_cfg;
    logic               pulse_hand;
    logic [LEVEL_W-1:0] pulse_level;

    assign cfg_ready = 1'b1;
    assign take_cfg  = cfg_valid && cfg_ready;

    hapenv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hapenv_datapath #(
        .HAND_COUNT (HAND_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .in_func   (s_tuser),
        .cfg_we    (take_cfg),
        .cfg_value (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_hand  (pulse_hand),
        .out_level (pulse_level)
    );

    assign m_tdata = {2'b00, pulse_level, pulse_hand};

endmodule
`default_nettype wire
